// File: src/assert_macros.svh
// Assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pwft_pkg.sv
package pwft_pkg;

  localparam int FRAME_BITS = 41;
  localparam int TIME_WIDTH = 16;
  localparam int BURST_W    = 32;
  localparam int POS_W      = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int CFG_W      = (FRAME_BITS > TIME_WIDTH) ? FRAME_BITS : TIME_WIDTH;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PATTERN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP     = 3'd7;

  typedef logic [TIME_WIDTH-1:0] ticks_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_pattern;
    ticks_t                start_high_ticks;
    ticks_t                start_low_ticks;
    ticks_t                one_high_ticks;
    ticks_t                one_low_ticks;
    ticks_t                zero_high_ticks;
    ticks_t                zero_low_ticks;
    ticks_t                frame_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_end;
    logic start_ignored;
  } res_t;

endpackage

// File: src/pulse_width_frame_transmitter_unit.sv
// An accepted item goes to the input register, and its result to the output register.
// Throughput: one item per cycle unless out_stall; pwft_core state updates per item.
// Output register plus input register let a new item enter while a result waits.
// Reset (rst, synchronous, active high): idle, out_valid low, config to defaults.
module pulse_width_frame_transmitter_unit
  import pwft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [BURST_W-1:0]   burst_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 pin_level,
  output logic                 busy_res,
  output logic                 frame_end,
  output logic                 start_ignored,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t               cfg;
  res_t               res;
  res_t               res_q;
  logic               q_valid;
  logic               q_action;
  logic [BURST_W-1:0] q_burst;
  logic               out_free;
  logic               step;

  assign out_free = !out_valid || !out_stall;
  assign step     = q_valid && out_free;
  assign in_stall = q_valid && !out_free;

  pwft_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwft_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .action      (q_action),
    .burst_ticks (q_burst),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      q_valid <= 1'b1;
    end else if (step) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_action <= action;
      q_burst  <= burst_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign pin_level     = res_q.pin_level;
  assign busy_res      = res_q.busy_res;
  assign frame_end     = res_q.frame_end;
  assign start_ignored = res_q.start_ignored;

endmodule

// File: src/pwft_cfg.sv
module pwft_cfg
  import pwft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t   regs;
  ticks_t t_val;

  assign t_val = cfg_data[TIME_WIDTH-1:0];
  assign cfg   = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_pattern    <= '0;
      regs.start_high_ticks <= TIME_WIDTH'(150);
      regs.start_low_ticks  <= TIME_WIDTH'(73);
      regs.one_high_ticks   <= TIME_WIDTH'(73);
      regs.one_low_ticks    <= TIME_WIDTH'(14);
      regs.zero_high_ticks  <= TIME_WIDTH'(18);
      regs.zero_low_ticks   <= TIME_WIDTH'(60);
      regs.frame_gap_ticks  <= TIME_WIDTH'(450);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_PATTERN: regs.frame_pattern    <= cfg_data[FRAME_BITS-1:0];
        REG_START_HIGH:    regs.start_high_ticks <= t_val;
        REG_START_LOW:     regs.start_low_ticks  <= t_val;
        REG_ONE_HIGH:      regs.one_high_ticks   <= t_val;
        REG_ONE_LOW:       regs.one_low_ticks    <= t_val;
        REG_ZERO_HIGH:     regs.zero_high_ticks  <= t_val;
        REG_ZERO_LOW:      regs.zero_low_ticks   <= t_val;
        REG_FRAME_GAP:     regs.frame_gap_ticks  <= t_val;
        default: ;
      endcase
    end
  end

endmodule

// File: src/pwft_core.sv
module pwft_core
  import pwft_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               action,
  input  logic [BURST_W-1:0] burst_ticks,
  input  cfg_t               cfg,
  output res_t               res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START_HI = 3'd1;
  localparam logic [2:0] PH_START_LO = 3'd2;
  localparam logic [2:0] PH_BIT_HI   = 3'd3;
  localparam logic [2:0] PH_BIT_LO   = 3'd4;
  localparam logic [2:0] PH_GAP      = 3'd5;

  logic [2:0]         phase, phase_next;
  logic [POS_W-1:0]   bit_position, bit_position_next;
  ticks_t             ticks_left, ticks_left_next;
  logic [BURST_W-1:0] elapsed, elapsed_next;
  logic [BURST_W-1:0] burst_length, burst_length_next;

  logic [BURST_W-1:0] elapsed_inc;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   sel_pos;
  logic               last_bit;
  logic               cur_bit;
  logic               level;
  ticks_t             bit_high, bit_low;

  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign pos_inc     = bit_position + 1'b1;
  assign last_bit    = (bit_position >= POS_W'(FRAME_BITS - 1));
  assign level       = (phase == PH_START_HI) || (phase == PH_BIT_HI);

  always_comb begin
    case (phase)
      PH_START_LO: sel_pos = '0;
      PH_BIT_LO:   sel_pos = last_bit ? '0 : pos_inc;
      default:     sel_pos = bit_position;
    endcase
  end

  assign cur_bit  = cfg.frame_pattern[sel_pos];
  assign bit_high = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign bit_low  = cur_bit ? cfg.one_low_ticks : cfg.zero_low_ticks;

  always_comb begin
    phase_next        = phase;
    bit_position_next = bit_position;
    ticks_left_next   = ticks_left;
    elapsed_next      = elapsed;
    burst_length_next = burst_length;
    res               = '0;
    if (action) begin
      if (phase != PH_IDLE) begin
        res.pin_level     = level;
        res.busy_res      = 1'b1;
        res.start_ignored = 1'b1;
      end else begin
        burst_length_next = burst_ticks;
        elapsed_next      = '0;
        bit_position_next = '0;
        phase_next        = PH_START_HI;
        ticks_left_next   = cfg.start_high_ticks;
        res.pin_level     = 1'b1;
        res.busy_res      = 1'b1;
      end
    end else if (phase != PH_IDLE) begin
      res.pin_level = level;
      res.busy_res  = 1'b1;
      elapsed_next  = elapsed_inc;
      if (ticks_left > TIME_WIDTH'(1)) begin
        ticks_left_next = ticks_left - 1'b1;
      end else begin
        case (phase)
          PH_START_HI: begin
            phase_next      = PH_START_LO;
            ticks_left_next = cfg.start_low_ticks;
          end
          PH_START_LO: begin
            bit_position_next = '0;
            phase_next        = PH_BIT_HI;
            ticks_left_next   = bit_high;
          end
          PH_BIT_HI: begin
            phase_next      = PH_BIT_LO;
            ticks_left_next = bit_low;
          end
          PH_BIT_LO: begin
            if (last_bit) begin
              phase_next      = PH_GAP;
              ticks_left_next = cfg.frame_gap_ticks;
            end else begin
              bit_position_next = pos_inc;
              phase_next        = PH_BIT_HI;
              ticks_left_next   = bit_high;
            end
          end
          default: begin
            res.frame_end     = 1'b1;
            bit_position_next = '0;
            if (elapsed_inc < burst_length) begin
              phase_next      = PH_START_HI;
              ticks_left_next = cfg.start_high_ticks;
            end else begin
              phase_next      = PH_IDLE;
              ticks_left_next = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_position <= '0;
      ticks_left   <= '0;
      elapsed      <= '0;
      burst_length <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bit_position <= bit_position_next;
      ticks_left   <= ticks_left_next;
      elapsed      <= elapsed_next;
      burst_length <= burst_length_next;
    end
  end

endmodule

// File: src/pwft_checker.sv
`include "assert_macros.svh"

module pwft_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic pin_level,
  input logic busy_res,
  input logic frame_end,
  input logic start_ignored
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pin_level) && $stable(busy_res) && $stable(frame_end) && $stable(start_ignored), "stalled result item changed")
  `CHK_SAME(a_ign_busy, out_valid && start_ignored, busy_res && !frame_end, "dropped start without busy")
  `CHK_SAME(a_fend_low, out_valid && frame_end, busy_res && !pin_level, "frame end with pin high")
  `CHK_SAME(a_idle_low, out_valid && !busy_res, !pin_level && !frame_end && !start_ignored, "idle result not quiet")

endmodule

bind pulse_width_frame_transmitter_unit pwft_checker u_pwft_checker (.*);
